/* hw/rtl/bis_pkg.sv */
package bis_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_DRN_RD,
		S_DRN_LD,
		S_DRN_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_key;   // capture incoming value, point j at fill count
		logic rd_prev;    // read entry j-1
		logic wr_shift;   // entry j <= read data, j--
		logic wr_key;     // entry j <= key
		logic inc_count;
		logic clr_count;
		logic rd_drain;   // read entry k
		logic load_out;   // output register <= read data
		logic inc_k;
		logic clr_k;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic j_zero;
		logic key_lt;
		logic count_last;
		logic k_last;
	} sts_t;

endpackage

/* hw/rtl/bis_in_if.sv */
interface bis_in_if;
	import bis_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

/* hw/rtl/bis_out_if.sv */
interface bis_out_if;
	import bis_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     last;

	modport source (output valid, output sorted_value, output last, input ready);
	modport sink   (input valid, input sorted_value, input last, output ready);
endinterface

/* hw/rtl/bis_ctrl.sv */
module bis_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bis_pkg::sts_t sts,
	output bis_pkg::ctl_t ctl
);
	import bis_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_key = 1'b1;
					state_d      = S_INS_RD;
				end
			end
			S_INS_RD: begin
				if (sts.j_zero) begin
					ctl.wr_key = 1'b1;
					if (sts.count_last) begin
						ctl.clr_count = 1'b1;
						state_d       = S_DRN_RD;
					end else begin
						ctl.inc_count = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					ctl.rd_prev = 1'b1;
					state_d     = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (sts.key_lt) begin
					ctl.wr_shift = 1'b1;
					state_d      = S_INS_RD;
				end else begin
					ctl.wr_key = 1'b1;
					if (sts.count_last) begin
						ctl.clr_count = 1'b1;
						state_d       = S_DRN_RD;
					end else begin
						ctl.inc_count = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			S_DRN_RD: begin
				ctl.rd_drain = 1'b1;
				state_d      = S_DRN_LD;
			end
			S_DRN_LD: begin
				ctl.load_out = 1'b1;
				state_d      = S_DRN_OUT;
			end
			S_DRN_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.k_last) begin
						ctl.clr_k = 1'b1;
						state_d   = S_IDLE;
					end else begin
						ctl.inc_k = 1'b1;
						state_d   = S_DRN_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

/* hw/rtl/bis_datapath.sv */
module bis_datapath #(
	parameter int BATCH_SIZE = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bis_pkg::ctl_t                     ctl,
	output bis_pkg::sts_t                     sts,
	input  logic signed [bis_pkg::DATA_W-1:0] in_value,
	output logic signed [bis_pkg::DATA_W-1:0] out_value,
	output logic                              out_last
);
	import bis_pkg::*;

	localparam int AW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(BATCH_SIZE - 1);

	logic signed [DATA_W-1:0] mem [BATCH_SIZE];
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] key_q;
	logic [AW-1:0]            j_q;
	logic [AW-1:0]            count_q;
	logic [AW-1:0]            k_q;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic signed [DATA_W-1:0] wr_data;

	assign rd_addr = ctl.rd_drain ? k_q : (j_q - AW'(1));
	assign wr_en   = ctl.wr_shift | ctl.wr_key;
	assign wr_data = ctl.wr_shift ? rdata_q : key_q;

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[j_q] <= wr_data;
		end
		if (ctl.rd_prev | ctl.rd_drain) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_key) begin
			key_q <= in_value;
		end
		if (ctl.load_out) begin
			out_value <= rdata_q;
			out_last  <= (k_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			if (ctl.load_key) begin
				j_q <= count_q;
			end else if (ctl.wr_shift) begin
				j_q <= j_q - AW'(1);
			end
			if (ctl.clr_count) begin
				count_q <= '0;
			end else if (ctl.inc_count) begin
				count_q <= count_q + AW'(1);
			end
			if (ctl.clr_k) begin
				k_q <= '0;
			end else if (ctl.inc_k) begin
				k_q <= k_q + AW'(1);
			end
		end
	end

	assign sts.j_zero     = (j_q == '0);
	assign sts.key_lt     = (key_q < rdata_q);
	assign sts.count_last = (count_q == LAST_IDX);
	assign sts.k_last     = (k_q == LAST_IDX);
endmodule

/* hw/rtl/batch_integer_sorter.sv */
// channel  | dir | signals                          | request
// ---------+-----+----------------------------------+------------------------------
// samples  | in  | valid ready value[31:0]          | one signed value of the batch
// results  | out | valid ready sorted_value[31:0]   | next value ascending,
//          |     | last                             | last set on the final one
//
// Load: each request is inserted in place; larger stored values move up one
// entry at a time through the single memory port, then it fills the gap.
// Drain: each result is read, loaded into the output register and offered
// until results.ready takes it; the next read starts only after that.
// Reset (arst_n low) empties the batch; memory contents are not cleared.
// samples.ready is high only between insertions and while no batch drains;
// results hold while results.ready is low.
module batch_integer_sorter #(
	parameter int BATCH_SIZE = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	bis_in_if.sink   samples,
	bis_out_if.source results
);
	import bis_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer: insertion walk per request, then the drain of the full batch
	bis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// sorted store, pointers and output register
	bis_datapath #(
		.BATCH_SIZE (BATCH_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_value  (samples.value),
		.out_value (results.sorted_value),
		.out_last  (results.last)
	);
endmodule
